>>> rtl/i2cms_pkg.sv
// Package: status codes, commands and transfer payload types of the I2C master sequencer
package i2cms_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CMD_W = 2;
  localparam int ADDR_W = 7;
  localparam int CNT_W = 16;
  localparam int BYTE_W = 8;

  localparam logic [CMD_W-1:0] CMD_BEGIN_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVENT       = 2'd2;

  localparam logic [BYTE_W-1:0] ST_IDLE        = 8'hf8;
  localparam logic [BYTE_W-1:0] ST_START       = 8'h08;
  localparam logic [BYTE_W-1:0] ST_RESTART     = 8'h10;
  localparam logic [BYTE_W-1:0] ST_ADDR_W_ACK  = 8'h18;
  localparam logic [BYTE_W-1:0] ST_ADDR2_W_ACK = 8'hd0;
  localparam logic [BYTE_W-1:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [BYTE_W-1:0] ST_ADDR_R_ACK  = 8'h40;
  localparam logic [BYTE_W-1:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [BYTE_W-1:0] ST_DATA_R_NACK = 8'h58;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] status_code;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] tx_byte;
  } in_t;

  typedef struct packed {
    logic              issue_start;
    logic              write_data;
    logic              tx_taken;
    logic [BYTE_W-1:0] byte_value;
    logic              ack_enable;
    logic              clear_irq;
    logic              issue_stop;
    logic              rx_valid;
    logic              done_res;
    logic              error_flag;
    logic [BYTE_W-1:0] error_status;
    logic              busy_reject;
  } out_t;

endpackage

>>> rtl/i2cms_step.sv
// Combinational next-state and result decode for one command or status event
module i2cms_step #(
  parameter int COUNT_BITS = i2cms_pkg::COUNT_BITS_DEF
) (
  input  i2cms_pkg::in_t   item_i,
  input  logic             running_i,
  input  logic [7:0]       addr_byte_i,
  input  logic [COUNT_BITS-1:0] tx_rem_i,
  input  logic [COUNT_BITS-1:0] rx_rem_i,
  input  logic             ack_i,
  output logic             running_o,
  output logic [7:0]       addr_byte_o,
  output logic [COUNT_BITS-1:0] tx_rem_o,
  output logic [COUNT_BITS-1:0] rx_rem_o,
  output logic             ack_o,
  output i2cms_pkg::out_t  res_o
);
  import i2cms_pkg::*;

  localparam int WIDE_W = (COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W;

  logic [WIDE_W-1:0]     cnt_wide;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] rx_dec;
  logic                  is_begin;

  assign cnt_wide = WIDE_W'(item_i.count);
  assign cnt      = cnt_wide[COUNT_BITS-1:0];
  assign rx_dec   = (rx_rem_i != '0) ? rx_rem_i - COUNT_BITS'(1) : rx_rem_i;
  assign is_begin = (item_i.command == CMD_BEGIN_WRITE) || (item_i.command == CMD_BEGIN_READ);

  always_comb begin
    running_o   = running_i;
    addr_byte_o = addr_byte_i;
    tx_rem_o    = tx_rem_i;
    rx_rem_o    = rx_rem_i;
    ack_o       = ack_i;
    res_o       = '0;
    if (is_begin) begin
      if (running_i) begin
        res_o.busy_reject = 1'b1;
      end else begin
        running_o   = 1'b1;
        addr_byte_o = {item_i.address, item_i.command == CMD_BEGIN_READ};
        if (item_i.command == CMD_BEGIN_READ) begin
          rx_rem_o = cnt;
          tx_rem_o = '0;
        end else begin
          tx_rem_o = cnt;
          rx_rem_o = '0;
        end
        ack_o             = 1'b0;
        res_o.issue_start = 1'b1;
      end
    end else if (item_i.command == CMD_EVENT && running_i) begin
      unique case (item_i.status_code) inside
        ST_IDLE: begin
          res_o.issue_stop = 1'b1;
          res_o.done_res   = 1'b1;
          running_o        = 1'b0;
        end
        ST_START, ST_RESTART: begin
          res_o.write_data = 1'b1;
          res_o.byte_value = addr_byte_i;
          res_o.clear_irq  = 1'b1;
        end
        ST_ADDR_W_ACK, ST_ADDR2_W_ACK, ST_DATA_W_ACK: begin
          if (tx_rem_i != '0) begin
            res_o.write_data = 1'b1;
            res_o.tx_taken   = 1'b1;
            res_o.byte_value = item_i.tx_byte;
            res_o.clear_irq  = 1'b1;
            tx_rem_o         = tx_rem_i - COUNT_BITS'(1);
          end else begin
            res_o.issue_stop = 1'b1;
            res_o.done_res   = 1'b1;
            running_o        = 1'b0;
          end
        end
        ST_ADDR_R_ACK: begin
          ack_o           = rx_rem_i > COUNT_BITS'(1);
          res_o.clear_irq = 1'b1;
        end
        ST_DATA_R_ACK: begin
          res_o.rx_valid   = 1'b1;
          res_o.byte_value = item_i.rx_byte;
          rx_rem_o         = rx_dec;
          if (rx_dec == COUNT_BITS'(1)) begin
            ack_o = 1'b0;
          end
          res_o.clear_irq = 1'b1;
        end
        ST_DATA_R_NACK: begin
          res_o.rx_valid   = 1'b1;
          res_o.byte_value = item_i.rx_byte;
          rx_rem_o         = rx_dec;
          res_o.issue_stop = 1'b1;
          res_o.done_res   = 1'b1;
          running_o        = 1'b0;
        end
        default: begin
          res_o.error_flag   = 1'b1;
          res_o.error_status = item_i.status_code;
          res_o.issue_stop   = 1'b1;
          res_o.done_res     = 1'b1;
          running_o          = 1'b0;
        end
      endcase
    end
    res_o.ack_enable = ack_o;
  end

endmodule

>>> rtl/i2c_master_status_sequencer_core.sv
// Top level: I2C master status sequencer with input register, decode and result register
//
//   channel  direction  valid        stall        payload
//   in       input      in_valid_i   in_stall_o   in_i  (i2cms_pkg::in_t)
//   out      output     out_valid_o  out_stall_i  out_o (i2cms_pkg::out_t)
//
// One transfer in per cycle unless in_stall_o is high, one result out per transfer:
// the input register feeds the status decode, which updates the sequencer state
// and loads the result register in the same cycle. Reset clears the state and both
// valid bits. A stall on the output holds the result and, once the input register
// is also full, raises in_stall_o.
module i2c_master_status_sequencer_core #(
  parameter int COUNT_BITS = i2cms_pkg::COUNT_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  i2cms_pkg::in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output i2cms_pkg::out_t out_o
);
  import i2cms_pkg::*;

  in_t                   in_q;
  logic                  in_valid_q;
  out_t                  out_q, res_d;
  logic                  out_valid_q;
  logic                  running_q, running_d;
  logic [7:0]            addr_byte_q, addr_byte_d;
  logic [COUNT_BITS-1:0] tx_rem_q, tx_rem_d;
  logic [COUNT_BITS-1:0] rx_rem_q, rx_rem_d;
  logic                  ack_q, ack_d;
  logic                  advance;
  logic                  in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  i2cms_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .item_i      (in_q),
    .running_i   (running_q),
    .addr_byte_i (addr_byte_q),
    .tx_rem_i    (tx_rem_q),
    .rx_rem_i    (rx_rem_q),
    .ack_i       (ack_q),
    .running_o   (running_d),
    .addr_byte_o (addr_byte_d),
    .tx_rem_o    (tx_rem_d),
    .rx_rem_o    (rx_rem_d),
    .ack_o       (ack_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      running_q   <= 1'b0;
      addr_byte_q <= '0;
      tx_rem_q    <= '0;
      rx_rem_q    <= '0;
      ack_q       <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        running_q   <= running_d;
        addr_byte_q <= addr_byte_d;
        tx_rem_q    <= tx_rem_d;
        rx_rem_q    <= rx_rem_d;
        ack_q       <= ack_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> rtl/i2cms_checker.sv
// Checker: port-level properties of the I2C master status sequencer, bound to the top level
module i2cms_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input i2cms_pkg::out_t out_o
);
  import i2cms_pkg::*;

  logic run_q;
  logic out_done;

  assign out_done = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (out_done) begin
      if (out_o.issue_start) begin
        run_q <= 1'b1;
      end else if (out_o.done_res) begin
        run_q <= 1'b0;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_done && out_o.issue_start |-> !run_q)
    else $error("start issued while a transfer runs");

  a_busy_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_done && out_o.busy_reject |-> run_q)
    else $error("begin refused while idle");

  a_stop_no_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.issue_stop |-> !out_o.clear_irq && out_o.done_res)
    else $error("stop without done or with irq clear");

endmodule

bind i2c_master_status_sequencer_core i2cms_checker u_i2cms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

>>> tb/tb_top.sv
// Testbench for the I2C master status sequencer: directed and random transfers checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import i2cms_pkg::*;

  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  i2c_master_status_sequencer_core #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer state as seen by the predictor
  logic                  seq_busy;
  logic [BYTE_W-1:0]     addr_byte;
  logic [COUNT_BITS-1:0] tx_left;
  logic [COUNT_BITS-1:0] rx_left;
  logic                  ack_on;

  out_t expected_q[$];
  out_t want_res;
  int   n_errors = 0;
  int   n_sent = 0;
  int   gap_max = 18;
  int   stall_max = 18;
  int   hold_req = 0;

  function automatic out_t predict_seq(input in_t it);
    out_t r;
    logic stop_now;
    r = '0;
    stop_now = 1'b0;
    if (it.command == CMD_BEGIN_WRITE || it.command == CMD_BEGIN_READ) begin
      if (seq_busy) begin
        r.busy_reject = 1'b1;
      end else begin
        seq_busy  = 1'b1;
        addr_byte = {it.address, it.command == CMD_BEGIN_READ};
        if (it.command == CMD_BEGIN_READ) begin
          rx_left = it.count[COUNT_BITS-1:0];
          tx_left = '0;
        end else begin
          tx_left = it.count[COUNT_BITS-1:0];
          rx_left = '0;
        end
        ack_on        = 1'b0;
        r.issue_start = 1'b1;
      end
    end else if (it.command == CMD_EVENT && seq_busy) begin
      case (it.status_code)
        ST_IDLE: begin
          stop_now = 1'b1;
        end
        ST_START, ST_RESTART: begin
          r.write_data = 1'b1;
          r.byte_value = addr_byte;
          r.clear_irq  = 1'b1;
        end
        ST_ADDR_W_ACK, ST_ADDR2_W_ACK, ST_DATA_W_ACK: begin
          if (tx_left != 0) begin
            r.write_data = 1'b1;
            r.tx_taken   = 1'b1;
            r.byte_value = it.tx_byte;
            r.clear_irq  = 1'b1;
            tx_left      = tx_left - COUNT_BITS'(1);
          end else begin
            stop_now = 1'b1;
          end
        end
        ST_ADDR_R_ACK: begin
          ack_on      = rx_left > 1;
          r.clear_irq = 1'b1;
        end
        ST_DATA_R_ACK: begin
          r.rx_valid   = 1'b1;
          r.byte_value = it.rx_byte;
          if (rx_left != 0) rx_left = rx_left - COUNT_BITS'(1);
          if (rx_left == 1) ack_on = 1'b0;
          r.clear_irq = 1'b1;
        end
        ST_DATA_R_NACK: begin
          r.rx_valid   = 1'b1;
          r.byte_value = it.rx_byte;
          if (rx_left != 0) rx_left = rx_left - COUNT_BITS'(1);
          stop_now = 1'b1;
        end
        default: begin
          r.error_flag   = 1'b1;
          r.error_status = it.status_code;
          stop_now       = 1'b1;
        end
      endcase
    end
    if (stop_now) begin
      r.issue_stop = 1'b1;
      r.done_res   = 1'b1;
      seq_busy     = 1'b0;
    end
    r.ack_enable = ack_on;
    return r;
  endfunction

  task automatic report_error(input string msg);
    if (n_errors < 40) $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_error("result transfer with no expectation pending");
      end else begin
        want_res = expected_q.pop_front();
        check_field("issue_start", 8'(out_data.issue_start), 8'(want_res.issue_start));
        check_field("write_data", 8'(out_data.write_data), 8'(want_res.write_data));
        check_field("tx_taken", 8'(out_data.tx_taken), 8'(want_res.tx_taken));
        check_field("byte_value", out_data.byte_value, want_res.byte_value);
        check_field("ack_enable", 8'(out_data.ack_enable), 8'(want_res.ack_enable));
        check_field("clear_irq", 8'(out_data.clear_irq), 8'(want_res.clear_irq));
        check_field("issue_stop", 8'(out_data.issue_stop), 8'(want_res.issue_stop));
        check_field("rx_valid", 8'(out_data.rx_valid), 8'(want_res.rx_valid));
        check_field("done_res", 8'(out_data.done_res), 8'(want_res.done_res));
        check_field("error_flag", 8'(out_data.error_flag), 8'(want_res.error_flag));
        check_field("error_status", out_data.error_status, want_res.error_status);
        check_field("busy_reject", 8'(out_data.busy_reject), 8'(want_res.busy_reject));
      end
    end
  end

  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = $urandom_range(0, stall_max);
      end
      if (n > 0) begin
        @(negedge clk) out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input in_t item);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_seq(item));
    n_sent++;
  endtask

  function automatic in_t random_item();
    in_t it;
    it.command     = CMD_W'($urandom_range(0, 3));
    it.address     = ADDR_W'($urandom_range(0, 127));
    it.count       = CNT_W'($urandom_range(0, 65535));
    it.status_code = BYTE_W'($urandom_range(0, 255));
    it.rx_byte     = BYTE_W'($urandom_range(0, 255));
    it.tx_byte     = BYTE_W'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic send_begin(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [CNT_W-1:0] cnt);
    in_t it;
    it = random_item();
    it.command = cmd;
    it.address = addr;
    it.count   = cnt;
    send_item(it);
  endtask

  task automatic send_event(input logic [BYTE_W-1:0] st, input logic [BYTE_W-1:0] rx,
                            input logic [BYTE_W-1:0] tx);
    in_t it;
    it = random_item();
    it.command     = CMD_EVENT;
    it.status_code = st;
    it.rx_byte     = rx;
    it.tx_byte     = tx;
    send_item(it);
  endtask

  task automatic wait_drained();
    @(negedge clk) in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_abort();
    if ($urandom_range(0, 1)) send_event(ST_IDLE, BYTE_W'($urandom), BYTE_W'($urandom));
    else send_event(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0) send_item(random_item());
  endtask

  task automatic run_write_transfer();
    int n;
    int i;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
    send_begin(CMD_BEGIN_WRITE, ADDR_W'($urandom_range(0, 127)), CNT_W'(n));
    send_event(($urandom_range(0, 3) == 0) ? ST_RESTART : ST_START,
               BYTE_W'($urandom), BYTE_W'($urandom));
    maybe_noise();
    send_event($urandom_range(0, 1) ? ST_ADDR_W_ACK : ST_ADDR2_W_ACK,
               BYTE_W'($urandom), BYTE_W'($urandom));
    i = 0;
    while (seq_busy && i < 8) begin
      send_event(ST_DATA_W_ACK, BYTE_W'($urandom), BYTE_W'($urandom));
      maybe_noise();
      i++;
    end
    if (seq_busy) send_abort();
  endtask

  task automatic run_read_transfer();
    int n;
    int i;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
    send_begin(CMD_BEGIN_READ, ADDR_W'($urandom_range(0, 127)), CNT_W'(n));
    send_event(($urandom_range(0, 3) == 0) ? ST_RESTART : ST_START,
               BYTE_W'($urandom), BYTE_W'($urandom));
    maybe_noise();
    send_event(ST_ADDR_R_ACK, BYTE_W'($urandom), BYTE_W'($urandom));
    i = 0;
    while (seq_busy && rx_left > 1 && i < 8) begin
      send_event(ST_DATA_R_ACK, BYTE_W'($urandom), BYTE_W'($urandom));
      maybe_noise();
      i++;
    end
    if (seq_busy && rx_left <= 1) begin
      send_event(ST_DATA_R_NACK, BYTE_W'($urandom), BYTE_W'($urandom));
    end
    if (seq_busy) send_abort();
  endtask

  task automatic run_random_transfer();
    int kind;
    kind = $urandom_range(0, 99);
    if (seq_busy && $urandom_range(0, 3) != 0) send_abort();
    if (kind < 42) run_write_transfer();
    else if (kind < 84) run_read_transfer();
    else repeat ($urandom_range(1, 3)) send_item(random_item());
  endtask

  task automatic set_idling(input int gmax, input int smax);
    gap_max   = gmax;
    stall_max = smax;
  endtask

  task automatic test_idle_and_unused();
    send_event(ST_START, 8'hff, 8'hff);
    send_begin(CMD_UNUSED, 7'h55, 16'hffff);
  endtask

  task automatic test_directed_write();
    send_begin(CMD_BEGIN_WRITE, 7'h7f, 16'd2);
    send_event(ST_START, 8'h00, 8'h00);
    send_event(ST_ADDR_W_ACK, 8'h00, 8'hff);
    send_event(ST_DATA_W_ACK, 8'hff, 8'h00);
    send_event(ST_DATA_W_ACK, 8'h00, 8'ha5);
    send_begin(CMD_BEGIN_WRITE, 7'h00, 16'hffff);
    send_event(ST_RESTART, 8'h00, 8'h00);
    send_event(ST_ADDR2_W_ACK, 8'h00, 8'h3c);
    send_event(ST_IDLE, 8'h00, 8'h00);
  endtask

  task automatic test_directed_read();
    send_begin(CMD_BEGIN_READ, 7'h2a, 16'd1);
    send_event(ST_START, 8'h00, 8'h00);
    send_event(ST_ADDR_R_ACK, 8'h00, 8'h00);
    send_event(ST_DATA_R_NACK, 8'hff, 8'h00);
    send_begin(CMD_BEGIN_READ, 7'h15, 16'd3);
    send_event(ST_ADDR_R_ACK, 8'h00, 8'h00);
    send_event(ST_DATA_R_ACK, 8'h00, 8'hff);
    send_event(ST_DATA_R_ACK, 8'h5a, 8'h00);
    send_event(ST_DATA_R_NACK, 8'hc3, 8'h00);
    send_begin(CMD_BEGIN_READ, 7'h01, 16'd0);
    send_event(ST_DATA_R_ACK, 8'h81, 8'h00);
    send_event(ST_DATA_R_NACK, 8'h7e, 8'h00);
  endtask

  task automatic test_busy_and_errors();
    send_begin(CMD_BEGIN_WRITE, 7'h40, 16'd1);
    send_begin(CMD_BEGIN_READ, 7'h3f, 16'd4);
    send_event(8'h00, 8'h00, 8'h00);
    send_begin(CMD_BEGIN_READ, 7'h33, 16'h8000);
    send_event(8'hff, 8'h00, 8'h00);
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    int chunk_end;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      case ($urandom_range(0, 3))
        0: set_idling(18, 18);
        1: set_idling(0, 0);
        2: set_idling(0, 18);
        default: set_idling(18, 0);
      endcase
      chunk_end = n_sent + 150;
      while (n_sent < chunk_end && n_sent < stop_at) run_random_transfer();
    end
  endtask

  task automatic test_backpressure();
    int stop_at;
    set_idling(0, 0);
    hold_req = 300;
    stop_at = n_sent + 40;
    while (n_sent < stop_at) run_random_transfer();
    wait_drained();
    set_idling(18, 18);
  endtask

  task automatic test_drain_pause();
    int stop_at;
    set_idling(4, 4);
    stop_at = n_sent + 30;
    while (n_sent < stop_at) run_random_transfer();
    wait_drained();
    stop_at = n_sent + 30;
    while (n_sent < stop_at) run_random_transfer();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    seq_busy  = 1'b0;
    addr_byte = '0;
    tx_left   = '0;
    rx_left   = '0;
    ack_on    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    test_idle_and_unused();
    test_directed_write();
    test_directed_read();
    test_busy_and_errors();
    test_backpressure();
    test_random_traffic(800);
    test_drain_pause();

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
rtl/i2cms_pkg.sv
rtl/i2cms_step.sv
rtl/i2c_master_status_sequencer_core.sv
rtl/i2cms_checker.sv
tb/tb_top.sv
